>>> rtl/eps_pkg.sv
// ----------------------------------------------------------------------------
// eps_pkg: shared definitions for the epilogue pattern scanner
// Instruction masks, result status codes, register indexes and the
// classification word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package eps_pkg;

   localparam int unsigned QueueDepth = 2;

   localparam logic [31:0] M_LDR_ANY  = 32'h1E00_1C5F;
   localparam logic [31:0] M_LDR_LR   = 32'hFE00_FC5F;
   localparam logic [31:0] M_LDRD_R10 = 32'hFE00_FC7F;
   localparam logic [31:0] V_LDR_ANY  = 32'h0400_144C;
   localparam logic [31:0] V_LDR_LR   = 32'h2400_D44C;
   localparam logic [31:0] V_LDRD_R10 = 32'h2400_546C;
   localparam logic [31:0] M_ADD_SP   = 32'hFC00_FC7F;
   localparam logic [31:0] V_ADD_SP   = 32'h2400_B41B;
   localparam logic [31:0] M_RTS      = 32'h1C0F_1FFF;
   localparam logic [31:0] V_RTS      = 32'h0402_194F;

   localparam logic [31:0] TEXT_END_RESET = 32'h0000_7FFF;

   typedef enum logic [1:0] {
      REG_TEXT_END  = 2'd0,
      REG_STOP_LOW  = 2'd1,
      REG_STOP_HIGH = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_CONTINUE = 2'd0,
      ST_FOUND    = 2'd1,
      ST_STOP     = 2'd2,
      ST_PAST_END = 2'd3
   } status_type;

   typedef struct packed {
      logic               scan_start;
      logic               past_end;
      logic               stop_hit;
      logic               is_ldr_lr;
      logic               is_ldrd;
      logic               is_add_sp;
      logic               is_rts;
      logic               any_ld;
      logic signed [14:0] link_offset;
      logic signed [11:0] add_imm;
   } class_type;

endpackage

>>> rtl/eps_front.sv
// ----------------------------------------------------------------------------
// eps_front: word intake and classification
// Holds the configuration registers, decodes each instruction word against
// the fixed masks, checks the address window and registers the result.
// ----------------------------------------------------------------------------
module eps_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,
   input  logic                req_tuser,
   output logic                cls_valid,
   input  logic                cls_ready,
   output eps_pkg::class_type  cls_data
);

   logic [31:0]        text_end_ff;
   logic [31:0]        stop_low_ff;
   logic [31:0]        stop_high_ff;
   logic               valid_ff;
   eps_pkg::class_type cls_ff;
   eps_pkg::class_type cls_in;
   logic [31:0]        word;
   logic [31:0]        addr;
   logic [10:0]        imm11;
   logic [14:0]        shifted;

   assign word    = req_tdata[31:0];
   assign addr    = req_tdata[63:32];
   assign imm11   = {word[23:16], word[9:7]};
   assign shifted = {4'b0, imm11} << word[6:5];

   always_comb begin
      cls_in.scan_start  = req_tuser;
      cls_in.past_end    = addr > text_end_ff;
      cls_in.stop_hit    = (addr >= stop_low_ff) && (addr < stop_high_ff);
      cls_in.is_ldr_lr   = (word & eps_pkg::M_LDR_LR) == eps_pkg::V_LDR_LR;
      cls_in.is_ldrd     = (word & eps_pkg::M_LDRD_R10) == eps_pkg::V_LDRD_R10;
      cls_in.is_add_sp   = (word & eps_pkg::M_ADD_SP) == eps_pkg::V_ADD_SP;
      cls_in.is_rts      = (word & eps_pkg::M_RTS) == eps_pkg::V_RTS;
      cls_in.any_ld      = (word & eps_pkg::M_LDR_ANY) == eps_pkg::V_LDR_ANY;
      cls_in.link_offset = word[24] ? (15'd0 - shifted) : shifted;
      cls_in.add_imm     = {imm11[10], imm11};
   end

   assign req_tready = !valid_ff || cls_ready;
   assign cls_valid  = valid_ff;
   assign cls_data   = cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_end_ff  <= eps_pkg::TEXT_END_RESET;
         stop_low_ff  <= '0;
         stop_high_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               eps_pkg::REG_TEXT_END:  text_end_ff  <= csr_wdata;
               eps_pkg::REG_STOP_LOW:  stop_low_ff  <= csr_wdata;
               eps_pkg::REG_STOP_HIGH: stop_high_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tready) begin
            valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cls_ff <= cls_in;
      end
   end

endmodule

>>> rtl/eps_queue.sv
// ----------------------------------------------------------------------------
// eps_queue: classification queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module eps_queue #(
   parameter int unsigned Depth = eps_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  eps_pkg::class_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output eps_pkg::class_type  out_data
);

   localparam int unsigned PtrWidth = $clog2(Depth);
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] Full    = CntWidth'(Depth);

   eps_pkg::class_type  mem [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff;
   logic [PtrWidth-1:0] rd_ptr_ff;
   logic [CntWidth-1:0] count_ff;
   logic                push;
   logic                pop;

   assign in_ready  = count_ff != Full;
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

>>> rtl/eps_back.sv
// ----------------------------------------------------------------------------
// eps_back: epilogue match sequencer
// Tracks the match phase, captures link offset and frame size, and drives
// the registered result word.
// ----------------------------------------------------------------------------
module eps_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cls_valid,
   output logic                cls_ready,
   input  eps_pkg::class_type  cls_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LDRD = 2'd1,
      PH_LINK = 2'd2,
      PH_ADD  = 2'd3
   } phase_type;

   phase_type           phase_ff;
   phase_type           phase_in;
   phase_type           phase_cur;
   logic [2:0]          adjust_ff;
   logic [2:0]          adjust_in;
   logic [2:0]          adjust_cur;
   logic [14:0]         link_ff;
   logic [14:0]         link_in;
   logic [11:0]         frame_ff;
   logic [11:0]         frame_in;
   eps_pkg::status_type status_in;
   logic                rsp_valid_ff;
   eps_pkg::status_type rsp_status_ff;
   logic [11:0]         rsp_frame_ff;
   logic [14:0]         rsp_link_ff;
   logic [2:0]          rsp_step_ff;
   logic                take;

   assign cls_ready = !rsp_valid_ff || rsp_tready;
   assign take      = cls_valid && cls_ready;

   always_comb begin
      phase_cur  = cls_data.scan_start ? PH_IDLE : phase_ff;
      adjust_cur = cls_data.scan_start ? 3'd0 : adjust_ff;
      phase_in   = phase_cur;
      adjust_in  = adjust_cur;
      link_in    = link_ff;
      frame_in   = frame_ff;
      status_in  = eps_pkg::ST_CONTINUE;
      if (cls_data.past_end) begin
         status_in = eps_pkg::ST_PAST_END;
      end else if (cls_data.stop_hit) begin
         status_in = eps_pkg::ST_STOP;
      end else begin
         case (phase_cur)
            PH_IDLE, PH_LDRD: begin
               if (cls_data.is_ldr_lr) begin
                  link_in  = cls_data.link_offset;
                  phase_in = PH_LINK;
               end else if (cls_data.is_ldrd) begin
                  adjust_in = 3'd4;
                  phase_in  = PH_LDRD;
               end
            end
            PH_LINK: begin
               if (cls_data.is_add_sp) begin
                  frame_in = cls_data.add_imm + {9'd0, adjust_cur};
                  phase_in = PH_ADD;
               end else if (!cls_data.any_ld) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               if (cls_data.is_rts) begin
                  status_in = eps_pkg::ST_FOUND;
                  phase_in  = PH_IDLE;
               end else if (!cls_data.any_ld) begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
         if (phase_in == PH_IDLE) begin
            adjust_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         adjust_ff    <= '0;
         link_ff      <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cls_ready) begin
            rsp_valid_ff <= cls_valid;
         end
         if (take) begin
            phase_ff  <= phase_in;
            adjust_ff <= adjust_in;
            link_ff   <= link_in;
            frame_ff  <= frame_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_status_ff <= status_in;
         rsp_frame_ff  <= frame_in;
         rsp_link_ff   <= link_in;
         rsp_step_ff   <= (phase_in == PH_IDLE) ? 3'd2 : 3'd4;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_step_ff, rsp_link_ff, rsp_frame_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_found_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == eps_pkg::ST_FOUND |-> rsp_step_ff == 3'd2)
      else $error("found result without return to idle");

   a_idle_no_adjust: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> adjust_ff == 3'd0)
      else $error("frame adjust left set while idle");

   a_adjust_values: assert property (@(posedge clock) disable iff (reset)
      adjust_ff == 3'd0 || adjust_ff == 3'd4)
      else $error("frame adjust out of range");

   a_step_phase: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_step_ff == 3'd2) == (phase_ff == PH_IDLE))
      else $error("step does not follow phase");

endmodule

>>> rtl/epilogue_pattern_scanner.sv
// ----------------------------------------------------------------------------
// epilogue_pattern_scanner: function epilogue search over an instruction stream
// Path: an accepted word passes the intake register, the queue and the result
// register before its result shows on rsp; phase_in is computed combinationally.
// Throughput: one word per cycle while rsp_tready does not stall the output.
// Reset: synchronous; clears the match state, saved offsets and queue, and
// loads the registers with their defaults (text end 0x7FFF, stop range empty).
// ----------------------------------------------------------------------------
module epilogue_pattern_scanner #(
   parameter int unsigned QueueDepth = eps_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // instr_word, instr_addr
   input  logic        req_tuser,   // scan_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // frame_size, link_offset, next_step
   output logic [1:0]  rsp_tuser    // scan_status
);

   logic               f_valid;
   logic               f_ready;
   eps_pkg::class_type f_data;
   logic               b_valid;
   logic               b_ready;
   eps_pkg::class_type b_data;

   eps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cls_valid  (f_valid),
      .cls_ready  (f_ready),
      .cls_data   (f_data)
   );

   eps_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   eps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cls_valid  (b_valid),
      .cls_ready  (b_ready),
      .cls_data   (b_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/epilogue_pattern_scanner_tb.sv
// ----------------------------------------------------------------------------
// epilogue_pattern_scanner_tb: self-checking bench for the epilogue scanner
// Streams instruction words with their addresses into the scanner and checks
// every result word against a cycle-free phase model or fixed values. The run
// opens with a directed table of boundary cases. It then feeds random
// epilogue sequences, noise and broken sequences under several register
// settings, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module epilogue_pattern_scanner_tb;

   localparam logic [2:0]  STEP_IDLE       = 3'd2;
   localparam logic [2:0]  STEP_BUSY       = 3'd4;
   localparam logic [31:0] LR_LOAD_NEG_MAX = 32'h25FF_D7EC;
   localparam logic [31:0] LR_LOAD_POS_MAX = 32'h24FF_D7EC;
   localparam logic [31:0] SP_ADD_POS_MAX  = 32'h247F_B79B;
   localparam logic [31:0] SP_ADD_NEG_MAX  = 32'h2480_B41B;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          QUIET_LIMIT     = 1000;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PAIR  = 2'd1,
      PH_LINK  = 2'd2,
      PH_FRAME = 2'd3
   } phase_type;

   typedef struct packed {
      eps_pkg::status_type status;
      logic [11:0]         frame;
      logic [14:0]         link;
      logic [2:0]          step;
   } scan_result_type;

   typedef enum logic {ROW_WORD, ROW_REGS} row_kind_type;

   // regs rows: word = text end, addr = stop low, limit = stop high
   typedef struct packed {
      row_kind_type    kind;
      logic [31:0]     word;
      logic [31:0]     addr;
      logic            start;
      logic [31:0]     limit;
      logic            known;
      scan_result_type want;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = eps_pkg::REG_TEXT_END;
   logic [31:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // instr_word, instr_addr
   logic        req_tuser  = 1'b0; // scan_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // frame_size, link_offset, next_step
   logic [1:0]  rsp_tuser;         // scan_status

   epilogue_pattern_scanner DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // model state and register shadow
   logic [31:0] text_end   = eps_pkg::TEXT_END_RESET;
   logic [31:0] stop_lo    = '0;
   logic [31:0] stop_hi    = '0;
   phase_type   phase      = PH_IDLE;
   logic [2:0]  frame_adj  = '0;
   logic [14:0] link_saved = '0;
   logic [11:0] frame_saved = '0;

   scan_result_type pending_results[$];
   dir_row_type     dir_rows[$];
   bit              calm = 1'b0;
   int              errors = 0;
   int              words_sent = 0;
   int              words_checked = 0;
   int              found_count = 0;
   int              stop_count = 0;
   int              past_count = 0;
   int              settings_used = 1;
   int              quiet = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic scan_result_type scan_predict(input logic [31:0] w,
                                                    input logic [31:0] a,
                                                    input logic st);
      scan_result_type r;
      logic [10:0]     imm;
      logic [14:0]     off;
      logic            any_ld;
      r.status = eps_pkg::ST_CONTINUE;
      imm = {w[23:16], w[9:7]};
      any_ld = (w & eps_pkg::M_LDR_ANY) == eps_pkg::V_LDR_ANY;
      if (st) begin
         phase = PH_IDLE;
         frame_adj = '0;
      end
      if (a > text_end) begin
         r.status = eps_pkg::ST_PAST_END;
      end else if (a >= stop_lo && a < stop_hi) begin
         r.status = eps_pkg::ST_STOP;
      end else begin
         case (phase)
            PH_IDLE, PH_PAIR: begin
               if ((w & eps_pkg::M_LDR_LR) == eps_pkg::V_LDR_LR) begin
                  off = 15'(imm) << w[6:5];
                  if (w[24]) off = -off;
                  link_saved = off;
                  phase = PH_LINK;
               end else if ((w & eps_pkg::M_LDRD_R10) == eps_pkg::V_LDRD_R10) begin
                  frame_adj = 3'd4;
                  phase = PH_PAIR;
               end
            end
            PH_LINK: begin
               if ((w & eps_pkg::M_ADD_SP) == eps_pkg::V_ADD_SP) begin
                  frame_saved = {imm[10], imm} + 12'(frame_adj);
                  phase = PH_FRAME;
               end else if (!any_ld) begin
                  phase = PH_IDLE;
               end
            end
            default: begin
               if ((w & eps_pkg::M_RTS) == eps_pkg::V_RTS) begin
                  r.status = eps_pkg::ST_FOUND;
                  phase = PH_IDLE;
               end else if (!any_ld) begin
                  phase = PH_IDLE;
               end
            end
         endcase
         if (phase == PH_IDLE) frame_adj = '0;
      end
      r.frame = frame_saved;
      r.link = link_saved;
      r.step = (phase == PH_IDLE) ? STEP_IDLE : STEP_BUSY;
      return r;
   endfunction

   function automatic dir_row_type row_pred(input logic [31:0] w, input logic [31:0] a,
                                            input logic st);
      dir_row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.word = w;
      r.addr = a;
      r.start = st;
      return r;
   endfunction

   function automatic dir_row_type row_known(input logic [31:0] w, input logic [31:0] a,
                                             input logic st,
                                             input eps_pkg::status_type s,
                                             input logic [11:0] f, input logic [14:0] l,
                                             input logic [2:0] n);
      dir_row_type r;
      r = row_pred(w, a, st);
      r.known = 1'b1;
      r.want.status = s;
      r.want.frame = f;
      r.want.link = l;
      r.want.step = n;
      return r;
   endfunction

   function automatic dir_row_type row_regs(input logic [31:0] te, input logic [31:0] lo,
                                            input logic [31:0] hi);
      dir_row_type r;
      r = '0;
      r.kind = ROW_REGS;
      r.word = te;
      r.addr = lo;
      r.limit = hi;
      return r;
   endfunction

   function automatic logic [31:0] fill(input logic [31:0] mask, input logic [31:0] value);
      return ($urandom & ~mask) | value;
   endfunction

   function automatic logic [31:0] pick_addr();
      logic [31:0] base;
      case ($urandom_range(9))
         0, 1: return $urandom;
         2, 3, 4: begin
            case ($urandom_range(2))
               0: base = text_end;
               1: base = stop_lo;
               default: base = stop_hi;
            endcase
            return base + $urandom_range(96) - 32'd48;
         end
         default: return $urandom_range(32'hFFFF);
      endcase
   endfunction

   // assumes entry at a falling edge; returns at a falling edge
   task automatic send_word(input logic [31:0] w, input logic [31:0] a, input logic st,
                            input logic known, input scan_result_type want);
      scan_result_type r;
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {a, w};
      req_tuser <= st;
      do @(posedge clock); while (!req_tready);
      r = scan_predict(w, a, st);
      pending_results.push_back(known ? want : r);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_regs(input logic [31:0] te, input logic [31:0] lo, input logic [31:0] hi);
      csr_we <= 1'b1;
      csr_index <= eps_pkg::REG_TEXT_END;
      csr_wdata <= te;
      @(negedge clock);
      csr_index <= eps_pkg::REG_STOP_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= eps_pkg::REG_STOP_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we <= 1'b0;
      text_end = te;
      stop_lo = lo;
      stop_hi = hi;
   endtask

   task automatic feed_sequence(inout int sent);
      logic [31:0]     a;
      logic            st;
      scan_result_type none;
      none = '0;
      a = pick_addr();
      st = 1'($urandom_range(1));
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 4)) begin
            send_word($urandom, a, st, 1'b0, none);
            a += 4;
            st = ($urandom_range(19) == 0);
            sent++;
         end
      end else begin
         if ($urandom_range(1)) begin
            send_word(fill(eps_pkg::M_LDRD_R10, eps_pkg::V_LDRD_R10), a, st, 1'b0, none);
            a += 4;
            st = 1'b0;
            sent++;
         end
         repeat ($urandom_range(2)) begin
            send_word(fill(eps_pkg::M_LDR_ANY, eps_pkg::V_LDR_ANY), a, st, 1'b0, none);
            a += 4;
            st = 1'b0;
            sent++;
         end
         send_word(fill(eps_pkg::M_LDR_LR, eps_pkg::V_LDR_LR), a, st, 1'b0, none);
         a += 4;
         sent++;
         repeat ($urandom_range(2)) begin
            send_word(fill(eps_pkg::M_LDR_ANY, eps_pkg::V_LDR_ANY), a,
                      ($urandom_range(24) == 0), 1'b0, none);
            a += 4;
            sent++;
         end
         if ($urandom_range(9) == 0) begin
            send_word($urandom, a, 1'b0, 1'b0, none);
            sent++;
            return;
         end
         send_word(fill(eps_pkg::M_ADD_SP, eps_pkg::V_ADD_SP), a, 1'b0, 1'b0, none);
         a += 4;
         sent++;
         repeat ($urandom_range(2)) begin
            send_word(fill(eps_pkg::M_LDR_ANY, eps_pkg::V_LDR_ANY), a,
                      ($urandom_range(24) == 0), 1'b0, none);
            a += 4;
            sent++;
         end
         if ($urandom_range(9) == 0) send_word($urandom, a, 1'b0, 1'b0, none);
         else send_word(fill(eps_pkg::M_RTS, eps_pkg::V_RTS), a, 1'b0, 1'b0, none);
         sent++;
      end
   endtask

   task automatic flag_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual tdata 0x%0h tuser %0d",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            flag_field("scan_status", 32'(want.status), 32'(rsp_tuser));
            flag_field("frame_size", 32'(want.frame), 32'(rsp_tdata[11:0]));
            flag_field("link_offset", 32'(want.link), 32'(rsp_tdata[26:12]));
            flag_field("next_step", 32'(want.step), 32'(rsp_tdata[29:27]));
            words_checked++;
            case (want.status)
               eps_pkg::ST_FOUND:    found_count++;
               eps_pkg::ST_STOP:     stop_count++;
               eps_pkg::ST_PAST_END: past_count++;
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      logic [31:0] te;
      logic [31:0] lo;
      logic [31:0] hi;
      int          budget;
      int          sent;
      dir_rows = '{
         row_known(32'h0, 32'h100, 1'b1, eps_pkg::ST_CONTINUE, 12'h0, 15'h0, STEP_IDLE),
         row_known(eps_pkg::V_LDR_LR, 32'hFFFF_FFFF, 1'b0, eps_pkg::ST_PAST_END,
                   12'h0, 15'h0, STEP_IDLE),
         row_known(eps_pkg::V_LDRD_R10, 32'h0000_8000, 1'b0, eps_pkg::ST_PAST_END,
                   12'h0, 15'h0, STEP_IDLE),
         row_pred(eps_pkg::V_LDRD_R10, 32'h0000_7FFF, 1'b0),
         row_pred(LR_LOAD_NEG_MAX, 32'h7000, 1'b0),
         row_pred(eps_pkg::V_LDR_ANY | ~eps_pkg::M_LDR_ANY, 32'h7004, 1'b0),
         row_pred(SP_ADD_POS_MAX, 32'h7008, 1'b0),
         row_pred(eps_pkg::V_RTS | ~eps_pkg::M_RTS, 32'h700C, 1'b0),
         row_pred(LR_LOAD_POS_MAX, 32'h0200, 1'b1),
         row_pred(SP_ADD_NEG_MAX, 32'h0204, 1'b0),
         row_pred(32'h0, 32'h0208, 1'b0),
         row_pred(eps_pkg::V_LDR_LR, 32'h020C, 1'b0),
         row_pred(32'hFFFF_FFFF, 32'h0210, 1'b0),
         row_pred(eps_pkg::V_LDRD_R10, 32'h0010, 1'b0),
         row_pred(eps_pkg::V_RTS, 32'hFFFF_FFFF, 1'b0),
         row_pred(eps_pkg::V_LDR_LR, 32'h0014, 1'b1),
         row_pred(eps_pkg::V_ADD_SP, 32'h0018, 1'b0),
         row_pred(eps_pkg::V_RTS, 32'h001C, 1'b0),
         row_regs(32'hFFFF_FFFF, 32'h0100, 32'h0200),
         row_pred(eps_pkg::V_LDRD_R10, 32'h0100, 1'b0),
         row_pred(eps_pkg::V_LDRD_R10, 32'h01FF, 1'b0),
         row_pred(eps_pkg::V_LDRD_R10, 32'h0200, 1'b0),
         row_pred(eps_pkg::V_LDR_LR, 32'h00FF, 1'b0),
         row_pred(eps_pkg::V_ADD_SP, 32'h01FE, 1'b0),
         row_pred(eps_pkg::V_ADD_SP, 32'hFFFF_FFFF, 1'b0),
         row_regs(eps_pkg::TEXT_END_RESET, 32'h0300, 32'h0100),
         row_pred(eps_pkg::V_RTS, 32'h0200, 1'b0)
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_REGS) begin
            wait_drain();
            set_regs(dir_rows[i].word, dir_rows[i].addr, dir_rows[i].limit);
            settings_used++;
         end else begin
            send_word(dir_rows[i].word, dir_rows[i].addr, dir_rows[i].start,
                      dir_rows[i].known, dir_rows[i].want);
         end
      end

      for (int s = 0; s < 7; s++) begin
         wait_drain();
         calm = 1'b0;
         budget = 100;
         case (s)
            0: begin
               te = 32'hFFFF_FFFF;
               lo = '0;
               hi = '0;
               budget = 110;
            end
            1: begin
               te = $urandom_range(32'h3FFF_FFFF, 32'h4000);
               lo = $urandom_range(te);
               hi = lo + $urandom_range(256, 8);
               budget = 110;
            end
            2: begin
               te = '0;
               lo = '0;
               hi = '0;
               budget = 30;
            end
            3: begin
               te = 32'hFFFF_FFFF;
               lo = '0;
               hi = 32'hFFFF_FFFF;
               budget = 40;
            end
            4: begin
               te = $urandom;
               lo = $urandom_range(32'hFFFF, 64);
               hi = lo - $urandom_range(64, 1);
            end
            5: begin
               calm = 1'b1;
               te = 32'h0010_0000;
               lo = $urandom_range(32'hFFFF);
               hi = lo + $urandom_range(128, 16);
               budget = 140;
            end
            default: begin
               te = eps_pkg::TEXT_END_RESET;
               lo = 32'd1000;
               hi = 32'd2000;
            end
         endcase
         set_regs(te, lo, hi);
         settings_used++;
         sent = 0;
         while (sent < budget) feed_sequence(sent);
      end

      wait_drain();
      $display("Checked %0d of %0d words under %0d register settings:", words_checked,
               words_sent, settings_used);
      $display("%0d epilogues found, %0d stop range hits, %0d past text end", found_count,
               stop_count, past_count);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
